>>> rtl/ims_pkg.sv
// Shared constants, types and codes for the image remap sampler.
// No dependencies; imported by the top level, ims_coord and ims_blend.
`timescale 1ns / 1ps
package ims_pkg;

  localparam int SRC_MAX_WIDTH   = 256;
  localparam int SRC_MAX_HEIGHT  = 256;
  localparam int COORD_FRAC_BITS = 8;

  localparam int CMD_W   = 2;
  localparam int PADDR_W = 16;
  localparam int PIX_W   = 8;
  localparam int COORD_W = 18;
  localparam int SIZE_W  = 9;
  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int COL_W       = $clog2(SRC_MAX_WIDTH);
  localparam int ROW_W       = $clog2(SRC_MAX_HEIGHT);
  localparam int FRAME_DEPTH = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int PROD_W      = ROW_W + SIZE_W;

  localparam int LIM_W = ((SIZE_W + COORD_FRAC_BITS > COORD_W) ?
                          SIZE_W + COORD_FRAC_BITS : COORD_W) + 2;
  localparam int AB_W  = PIX_W + COORD_FRAC_BITS + 1;
  localparam int SUM_W = AB_W + COORD_FRAC_BITS + 1;

  localparam int W_CAP_I = (SRC_MAX_WIDTH > 2**SIZE_W - 1) ? 2**SIZE_W - 1 : SRC_MAX_WIDTH;
  localparam int H_CAP_I = (SRC_MAX_HEIGHT > 2**SIZE_W - 1) ? 2**SIZE_W - 1 : SRC_MAX_HEIGHT;
  localparam logic [SIZE_W-1:0] W_CAP = SIZE_W'(W_CAP_I);
  localparam logic [SIZE_W-1:0] H_CAP = SIZE_W'(H_CAP_I);

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE  = 2'd3;

  typedef struct packed {
    logic                       border;
    logic [COL_W-1:0]           col0;
    logic [COL_W-1:0]           col1;
    logic [ROW_W-1:0]           row0;
    logic [ROW_W-1:0]           row1;
    logic [COORD_FRAC_BITS-1:0] fu;
    logic [COORD_FRAC_BITS-1:0] fv;
  } coord_t;

  typedef struct packed {
    logic load_a;
    logic calc_ab;
    logic calc_cd;
    logic calc_sum;
  } blend_ctl_t;

endpackage

>>> rtl/image_remap_sampler.sv
// Image remap sampler top level: command decode, read sequencer, frame store, counters.
// Load and clear complete while idle; a filled sample visits ST_FILL, a nearest one ST_RD_A
// and ST_NEAR, a bilinear one a frame store read per neighbour, then ST_CD, ST_SUM, ST_OUT.
// The result strobe rises in the same cycle as busy falls; the receiver cannot stall.
// Synchronous reset clears control, counters and registers; the frame store is not cleared.
`timescale 1ns / 1ps
module image_remap_sampler (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [ims_pkg::CMD_W-1:0]             cmd,
  input  logic [ims_pkg::PADDR_W-1:0]           pixel_addr,
  input  logic [ims_pkg::PIX_W-1:0]             pixel_data,
  input  logic signed [ims_pkg::COORD_W-1:0]    coord_x,
  input  logic signed [ims_pkg::COORD_W-1:0]    coord_y,
  input  logic                                  cfg_we,
  input  logic [ims_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ims_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                  done,
  output logic [ims_pkg::PIX_W-1:0]             out_pixel,
  output logic                                  is_border,
  output logic [ims_pkg::CNT_W-1:0]             sampled_cnt,
  output logic [ims_pkg::CNT_W-1:0]             fill_cnt,
  output logic [ims_pkg::CNT_W-1:0]             sample_cnt
);
  import ims_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_FILL = 4'd1;
  localparam logic [3:0] ST_RD_A = 4'd2;
  localparam logic [3:0] ST_NEAR = 4'd3;
  localparam logic [3:0] ST_RD_B = 4'd4;
  localparam logic [3:0] ST_RD_C = 4'd5;
  localparam logic [3:0] ST_RD_D = 4'd6;
  localparam logic [3:0] ST_CD   = 4'd7;
  localparam logic [3:0] ST_SUM  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [SIZE_W-1:0] src_width, src_height, wc, hc;
  logic              interp_mode;
  logic [PIX_W-1:0]  fill_pix;

  logic [3:0]        state, state_next;
  logic              accept, ld_we, fin;
  coord_t            dec, crd;
  blend_ctl_t        bctl;
  logic [ROW_W-1:0]  rd_row;
  logic [COL_W-1:0]  rd_col;
  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] raddr;
  logic [PIX_W-1:0]  rdata, blend_pix, fin_pix;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign ld_we  = accept && (cmd == CMD_LOAD) && (32'(pixel_addr) < 32'(FRAME_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width   <= SIZE_W'(256);
      src_height  <= SIZE_W'(256);
      interp_mode <= 1'b0;
      fill_pix    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:   src_width   <= cfg_data;
        REG_SRC_HEIGHT:  src_height  <= cfg_data;
        REG_INTERP_MODE: interp_mode <= cfg_data[0];
        REG_FILL_VALUE:  fill_pix    <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign wc = (src_width == '0) ? SIZE_W'(1) : ((src_width > W_CAP) ? W_CAP : src_width);
  assign hc = (src_height == '0) ? SIZE_W'(1) : ((src_height > H_CAP) ? H_CAP : src_height);

  ims_coord u_coord (
    .coord_x (coord_x),
    .coord_y (coord_y),
    .width   (wc),
    .height  (hc),
    .bilinear(interp_mode),
    .dec     (dec)
  );

  always_ff @(posedge clk) begin
    if (accept && (cmd == CMD_SAMPLE)) begin
      crd <= dec;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (cmd == CMD_SAMPLE)) begin
          state_next = dec.border ? ST_FILL : ST_RD_A;
        end
      end
      ST_FILL: state_next = ST_IDLE;
      ST_RD_A: state_next = interp_mode ? ST_RD_B : ST_NEAR;
      ST_NEAR: state_next = ST_IDLE;
      ST_RD_B: state_next = ST_RD_C;
      ST_RD_C: state_next = ST_RD_D;
      ST_RD_D: state_next = ST_CD;
      ST_CD:   state_next = ST_SUM;
      ST_SUM:  state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // neighbour order: a (r0,c0), b (r0,c1), c (r1,c0), d (r1,c1)
  always_comb begin
    case (state)
      ST_RD_B: begin rd_row = crd.row0; rd_col = crd.col1; end
      ST_RD_C: begin rd_row = crd.row1; rd_col = crd.col0; end
      ST_RD_D: begin rd_row = crd.row1; rd_col = crd.col1; end
      default: begin rd_row = crd.row0; rd_col = crd.col0; end
    endcase
  end

  assign prod  = PROD_W'(rd_row) * PROD_W'(wc);
  assign raddr = ADDR_W'(prod + PROD_W'(rd_col));

  ims_ram #(
    .WIDTH(PIX_W),
    .DEPTH(FRAME_DEPTH)
  ) u_frame (
    .clk  (clk),
    .we   (ld_we),
    .waddr(ADDR_W'(pixel_addr)),
    .wdata(pixel_data),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign bctl.load_a   = (state == ST_RD_B) || (state == ST_RD_D);
  assign bctl.calc_ab  = (state == ST_RD_C);
  assign bctl.calc_cd  = (state == ST_CD);
  assign bctl.calc_sum = (state == ST_SUM);

  ims_blend u_blend (
    .clk  (clk),
    .ctl  (bctl),
    .rdata(rdata),
    .fu   (crd.fu),
    .fv   (crd.fv),
    .pix  (blend_pix)
  );

  assign fin = (state == ST_FILL) || (state == ST_NEAR) || (state == ST_OUT);

  always_comb begin
    case (state)
      ST_FILL: fin_pix = fill_pix;
      ST_NEAR: fin_pix = rdata;
      default: fin_pix = blend_pix;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      out_pixel   <= '0;
      is_border   <= 1'b0;
      sampled_cnt <= '0;
      fill_cnt    <= '0;
      sample_cnt  <= '0;
    end else begin
      done <= fin;
      if (accept && (cmd == CMD_CLEAR)) begin
        sampled_cnt <= '0;
        fill_cnt    <= '0;
        sample_cnt  <= '0;
      end else if (fin) begin
        out_pixel <= fin_pix;
        is_border <= (state == ST_FILL);
        if (state == ST_FILL) begin
          if (fill_cnt != '1) fill_cnt <= fill_cnt + CNT_W'(1);
        end else begin
          if (sampled_cnt != '1) sampled_cnt <= sampled_cnt + CNT_W'(1);
        end
        if (sample_cnt != '1) sample_cnt <= sample_cnt + CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in flight");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("sequencer still busy while result is shown");

  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    (done && (sample_cnt != '1)) |->
      ((CNT_W+1)'(sampled_cnt) + (CNT_W+1)'(fill_cnt) == (CNT_W+1)'(sample_cnt)))
    else $error("sample counters disagree");
`endif

endmodule

>>> rtl/ims_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ims_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ims_coord.sv
// Coordinate decode: range checks, neighbour indices and fractions for both modes.
// Depends on ims_pkg.
`timescale 1ns / 1ps
module ims_coord (
  input  logic signed [ims_pkg::COORD_W-1:0] coord_x,
  input  logic signed [ims_pkg::COORD_W-1:0] coord_y,
  input  logic [ims_pkg::SIZE_W-1:0]         width,
  input  logic [ims_pkg::SIZE_W-1:0]         height,
  input  logic                               bilinear,
  output ims_pkg::coord_t                    dec
);
  import ims_pkg::*;

  localparam logic signed [LIM_W-1:0] HALF_S = LIM_W'(2**(COORD_FRAC_BITS-1));
  localparam int CMP_W = SIZE_W + COL_W + ROW_W;

  logic signed [LIM_W-1:0] xs, ys, xr, yr, xb, yb, xn, yn;
  logic [SIZE_W-1:0]       wm1, hm1;
  logic                    sentinel, brd_near, brd_bil;
  logic [COL_W-1:0]        u0;
  logic [ROW_W-1:0]        v0;

  assign xs  = LIM_W'(coord_x);
  assign ys  = LIM_W'(coord_y);
  assign wm1 = width - SIZE_W'(1);
  assign hm1 = height - SIZE_W'(1);
  assign xb  = signed'(LIM_W'(wm1) << COORD_FRAC_BITS);
  assign yb  = signed'(LIM_W'(hm1) << COORD_FRAC_BITS);
  assign xn  = xb + HALF_S;
  assign yn  = yb + HALF_S;
  assign xr  = xs + HALF_S;
  assign yr  = ys + HALF_S;

  assign sentinel = (xs < -HALF_S) && (ys < -HALF_S);
  assign brd_near = (xs <= -HALF_S) || (ys <= -HALF_S) || (xs >= xn) || (ys >= yn);
  assign brd_bil  = xs[LIM_W-1] || ys[LIM_W-1] || (xs > xb) || (ys > yb);

  always_comb begin
    dec.border = sentinel || (bilinear ? brd_bil : brd_near);
    dec.fu     = xs[COORD_FRAC_BITS-1:0];
    dec.fv     = ys[COORD_FRAC_BITS-1:0];
    if (bilinear) begin
      u0 = COL_W'(xs >>> COORD_FRAC_BITS);
      v0 = ROW_W'(ys >>> COORD_FRAC_BITS);
    end else begin
      u0 = xs[LIM_W-1] ? '0 : COL_W'(xr >>> COORD_FRAC_BITS);
      v0 = ys[LIM_W-1] ? '0 : ROW_W'(yr >>> COORD_FRAC_BITS);
    end
    dec.col0 = u0;
    dec.row0 = v0;
    dec.col1 = (CMP_W'(u0) + CMP_W'(1) < CMP_W'(width)) ? u0 + COL_W'(1) : COL_W'(wm1);
    dec.row1 = (CMP_W'(v0) + CMP_W'(1) < CMP_W'(height)) ? v0 + ROW_W'(1) : ROW_W'(hm1);
  end

endmodule

>>> rtl/ims_blend.sv
// Bilinear blend datapath: horizontal pairs, vertical blend, rounding and clamp.
// Depends on ims_pkg; steered by the sequencer in the top level.
`timescale 1ns / 1ps
module ims_blend (
  input  logic                               clk,
  input  ims_pkg::blend_ctl_t                ctl,
  input  logic [ims_pkg::PIX_W-1:0]          rdata,
  input  logic [ims_pkg::COORD_FRAC_BITS-1:0] fu,
  input  logic [ims_pkg::COORD_FRAC_BITS-1:0] fv,
  output logic [ims_pkg::PIX_W-1:0]          pix
);
  import ims_pkg::*;

  localparam int WT_W = COORD_FRAC_BITS + 1;
  localparam logic [WT_W-1:0] ONE = WT_W'(2**COORD_FRAC_BITS);
  localparam logic [SUM_W-1:0] RND = SUM_W'(2**(2*COORD_FRAC_BITS-1));
  localparam logic [SUM_W-1:0] PIX_MAX_S = SUM_W'(2**PIX_W - 1);

  logic [PIX_W-1:0] pa;
  logic [AB_W-1:0]  ab, cd, pair;
  logic [SUM_W-1:0] sum, rnd;
  logic [WT_W-1:0]  wu, wv;

  assign wu   = ONE - WT_W'(fu);
  assign wv   = ONE - WT_W'(fv);
  assign pair = AB_W'(pa) * AB_W'(wu) + AB_W'(rdata) * AB_W'(fu);
  assign rnd  = (sum + RND) >> (2 * COORD_FRAC_BITS);
  assign pix  = (rnd > PIX_MAX_S) ? PIX_W'(PIX_MAX_S) : PIX_W'(rnd);

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      pa <= rdata;
    end
    if (ctl.calc_ab) begin
      ab <= pair;
    end
    if (ctl.calc_cd) begin
      cd <= pair;
    end
    if (ctl.calc_sum) begin
      sum <= SUM_W'(ab) * SUM_W'(wv) + SUM_W'(cd) * SUM_W'(fv);
    end
  end

endmodule
